// File: src/fuel_gauge_telemetry_converter_unit_assert.svh
// Assertion macros for the fuel gauge telemetry converter.
`ifndef FUEL_GAUGE_TELEMETRY_CONVERTER_UNIT_ASSERT_SVH
`define FUEL_GAUGE_TELEMETRY_CONVERTER_UNIT_ASSERT_SVH

// Checks that an implication holds at every clock edge outside reset.
`define FGT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that the consequent holds in the cycle after its antecedent.
`define FGT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/fgtc_pkg.sv
package fgtc_pkg;

  localparam int unsigned InW = 256;
  localparam int unsigned OutW = 96;
  localparam int unsigned QW = 50;
  localparam int unsigned Stages = QW + 2;

  localparam logic [31:0] IdExpected = 32'h2720A003;
  localparam logic [13:0] CurrZero = 14'h2000;
  localparam logic [19:0] Micro = 20'd1000000;
  localparam logic [12:0] SamplesPerHour = 13'd7200;
  localparam logic [22:0] UvMax = 23'd8388607;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StChip = 3'd1;
  localparam logic [2:0] StClock = 3'd2;
  localparam logic [2:0] StNoData = 3'd3;
  localparam logic [2:0] StRange = 3'd4;

  localparam logic CfgVolt = 1'b0;
  localparam logic CfgAmp = 1'b1;

  typedef struct packed {
    logic [2:0] vst;
    logic [2:0] cst;
    logic [2:0] qst;
    logic       cneg;
    logic       qneg;
  } status_t;

  // One restoring divider stage: shifts in the next numerator bit.
  typedef struct packed {
    logic [QW-1:0] num;
    logic [QW-1:0] rem;
    logic [QW-1:0] den;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t o;
    logic [QW:0] t;
    o = s;
    t = {s.rem, s.num[QW-1]};
    o.num = {s.num[QW-2:0], 1'b0};
    if (t >= {1'b0, s.den}) begin
      o.rem = QW'(t - {1'b0, s.den});
      o.num[0] = 1'b1;
    end else begin
      o.rem = t[QW-1:0];
    end
    return o;
  endfunction

endpackage

// File: src/fgtc_front.sv
module fgtc_front (
  input  logic                     clk,
  input  logic                     en,
  input  logic [fgtc_pkg::InW-1:0] data,
  input  logic [9:0]               cpv,
  input  logic [23:0]              cpa,
  output fgtc_pkg::status_t        st,
  output fgtc_pkg::div_t           vd,
  output fgtc_pkg::div_t           cd,
  output fgtc_pkg::div_t           qd
);
  import fgtc_pkg::*;

  logic [31:0] ident, cnt;
  logic [15:0] men, rtc, rst, chg, cfg, adc, sts, irq, cr, v0, v1, v2, med, lo, hi;
  logic [2:0] common, vst, cst, qst;
  logic [14:0] delta;
  logic [29:0] cmag;
  logic [QW-1:0] vnum, cnum, qnum, qden;
  logic [36:0] qden_full;
  status_t st_r;
  div_t vd_r, cd_r, qd_r;

  assign ident = data[31:0];
  assign men = data[47:32];
  assign rtc = data[63:48];
  assign rst = data[79:64];
  assign chg = data[95:80];
  assign cfg = data[111:96];
  assign adc = data[127:112];
  assign sts = data[143:128];
  assign irq = data[159:144];
  assign v0 = data[175:160];
  assign v1 = data[191:176];
  assign v2 = data[207:192];
  assign cr = data[223:208];
  assign cnt = data[255:224];

  always_comb begin
    if (ident != IdExpected) common = StChip;
    else if (!men[7]) common = StClock;
    else if (!rtc[6] || rst[4] || (chg[13:12] != 2'b0)) common = StNoData;
    else common = StOk;
    lo = (v0 < v1) ? v0 : v1;
    hi = (v0 < v1) ? v1 : v0;
    if (v2 < lo) med = lo;
    else if (v2 > hi) med = hi;
    else med = v2;
    vst = common;
    if (common == StOk && ((cfg[12:11] != 2'b0) || (adc[1:0] != 2'b0) || !sts[6] ||
        !irq[6] || v0 == 16'd0 || v1 == 16'd0 || v2 == 16'd0 ||
        ((v0 | v1 | v2) & 16'hF000) != 16'd0 || cpv == 10'd0)) vst = StNoData;
    cst = common;
    if (common == StOk && ((cfg[11] || cfg[3]) || (adc[7:4] != 4'd0) ||
        (adc[1:0] != 2'b0) || !sts[6] || !irq[7] || (cr[15:14] != 2'b0) ||
        cpa == 24'd0)) cst = StNoData;
    qst = cst;
    if (cst == StOk && cnt[31:29] != 3'b000 && cnt[31:29] != 3'b111) qst = StNoData;
    delta = {1'b0, cr[13:0]} - {1'b0, CurrZero};
    cmag = cnt[29] ? 30'(-cnt[29:0]) : cnt[29:0];
    vnum = QW'({med, 10'd0} - {med, 4'd0} - {med, 3'd0});
    cnum = QW'(delta[14] ? 15'(-delta) : delta) * QW'(Micro);
    qnum = QW'(cmag) * QW'(Micro);
    qden_full = 37'(cpa) * 37'(SamplesPerHour);
    qden = QW'(qden_full);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= '{vst: vst, cst: cst, qst: qst, cneg: delta[14], qneg: cnt[29]};
      vd_r <= '{num: vnum + QW'(cpv[9:1]), rem: '0, den: QW'(cpv)};
      cd_r <= '{num: cnum + QW'(cpa[23:1]), rem: '0, den: QW'(cpa)};
      qd_r <= '{num: qnum + QW'(qden[QW-1:1]), rem: '0, den: qden};
    end
  end

  assign st = st_r;
  assign vd = vd_r;
  assign cd = cd_r;
  assign qd = qd_r;
endmodule

// File: src/fgtc_divpipe.sv
module fgtc_divpipe (
  input  logic                  clk,
  input  logic                  en,
  input  fgtc_pkg::status_t     st_in,
  input  fgtc_pkg::div_t        vd_in,
  input  fgtc_pkg::div_t        cd_in,
  input  fgtc_pkg::div_t        qd_in,
  output fgtc_pkg::status_t     st_out,
  output logic [fgtc_pkg::QW-1:0] vq,
  output logic [fgtc_pkg::QW-1:0] cq,
  output logic [fgtc_pkg::QW-1:0] qq
);
  import fgtc_pkg::*;

  status_t st_r [QW];
  div_t vd_r [QW];
  div_t cd_r [QW];
  div_t qd_r [QW];

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st_in;
      vd_r[0] <= div_step(vd_in);
      cd_r[0] <= div_step(cd_in);
      qd_r[0] <= div_step(qd_in);
      for (int i = 1; i < QW; i++) begin
        st_r[i] <= st_r[i-1];
        vd_r[i] <= div_step(vd_r[i-1]);
        cd_r[i] <= div_step(cd_r[i-1]);
        qd_r[i] <= div_step(qd_r[i-1]);
      end
    end
  end

  assign st_out = st_r[QW-1];
  assign vq = vd_r[QW-1].num;
  assign cq = cd_r[QW-1].num;
  assign qq = qd_r[QW-1].num;
endmodule

// File: src/fuel_gauge_telemetry_converter_unit.sv
// Path: front register, divider stages, output register. Throughput: one snapshot
// per cycle unless the result side stalls; the dividers are 50-stage restoring pipelines.
// A stall on the result side freezes every stage, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// calibration registers to 622 codes per volt and zero codes per amp.
module fuel_gauge_telemetry_converter_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // chip_identity, module_enable_word, rtc_clock_word, soft_reset_word,
  // charger_detect_word, gauge_control_word, adc_control_word, gauge_status_word,
  // raw_interrupt_word, voltage_readings, current_reading, charge_count_word.
  input  logic [fgtc_pkg::InW-1:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // voltage_microvolts, voltage_result, current_ua, current_result,
  // charge_microamp_hours, charge_result, zero fill.
  output logic [fgtc_pkg::OutW-1:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_data
);
  import fgtc_pkg::*;
  `include "fuel_gauge_telemetry_converter_unit_assert.svh"

  logic [9:0] cpv_r;
  logic [23:0] cpa_r;
  logic [Stages-1:0] vld_r;
  logic en;
  status_t st_a, st_b;
  div_t vd, cd, qd;
  logic [QW-1:0] vq, cq, qq;
  logic [22:0] uv;
  logic [31:0] ua, uah;
  logic [2:0] cst, qst;
  logic [QW-1:0] uv_full;
  logic [OutW-1:0] out_r;

  assign en = !vld_r[Stages-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign out_tvalid = vld_r[Stages-1];
  assign out_tdata = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpv_r <= 10'd622;
      cpa_r <= 24'd0;
      vld_r <= '0;
    end else begin
      if (cfg_valid && cfg_index == CfgVolt) cpv_r <= cfg_data[9:0];
      if (cfg_valid && cfg_index == CfgAmp) cpa_r <= cfg_data;
      if (en) vld_r <= {vld_r[Stages-2:0], in_tvalid};
    end
  end

  fgtc_front u_front (
    .clk(clk), .en(en), .data(in_tdata), .cpv(cpv_r), .cpa(cpa_r),
    .st(st_a), .vd(vd), .cd(cd), .qd(qd)
  );

  fgtc_divpipe u_div (
    .clk(clk), .en(en), .st_in(st_a), .vd_in(vd), .cd_in(cd), .qd_in(qd),
    .st_out(st_b), .vq(vq), .cq(cq), .qq(qq)
  );

  always_comb begin
    uv_full = vq * QW'(1000);
    uv = (st_b.vst != StOk) ? 23'd0 : (uv_full > QW'(UvMax)) ? UvMax : uv_full[22:0];
    cst = st_b.cst;
    ua = 32'd0;
    if (cst == StOk) begin
      if (st_b.cneg ? (cq > QW'(33'h80000000)) : (cq > QW'(32'h7FFFFFFF))) cst = StRange;
      else ua = st_b.cneg ? 32'(-cq) : cq[31:0];
    end
    qst = (cst != StOk) ? cst : st_b.qst;
    uah = 32'd0;
    if (qst == StOk) begin
      if (st_b.qneg ? (qq > QW'(33'h80000000)) : (qq > QW'(32'h7FFFFFFF))) qst = StRange;
      else uah = st_b.qneg ? 32'(-qq) : qq[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= {1'b0, qst, uah, cst, ua, st_b.vst[1:0], uv};
  end

  `FGT_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `FGT_ASSERT_IMPL(a_ready, !out_tvalid, in_tready)
  `FGT_ASSERT_IMPL(a_zero_v, out_tvalid && out_tdata[24:23] != 2'd0, out_tdata[22:0] == 23'd0)
endmodule
